### rtl/b64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared payload types, group descriptor and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  localparam logic [1:0] PhaseStart = 2'd0;
  localparam logic [1:0] PhaseOne   = 2'd1;
  localparam logic [1:0] PhaseTwo   = 2'd2;

  localparam logic [1:0] CharLast = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  pads;
    logic        last;
  } grp_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

endpackage

### rtl/b64enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Collects bytes into three-byte groups and issues one group descriptor per
// completed or final group.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  b64enc_pkg::in_t   in_item_i,
  output logic              grp_push_o,
  output b64enc_pkg::grp_t  grp_o
);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  phase;
  logic [7:0]  b;

  assign b     = in_item_i.data_byte;
  assign phase = (phase_q == 2'd3) ? b64enc_pkg::PhaseStart : phase_q;

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    grp_push_o = 1'b0;
    grp_o      = '0;
    unique case (phase)
      b64enc_pkg::PhaseOne: begin
        grp_o.triple = {held_q[15:8], b, 8'h00};
        grp_o.pads   = 2'd1;
        grp_o.last   = 1'b1;
      end
      b64enc_pkg::PhaseTwo: begin
        grp_o.triple = {held_q, b};
        grp_o.pads   = 2'd0;
        grp_o.last   = in_item_i.final_byte;
      end
      default: begin
        grp_o.triple = {b, 16'h0000};
        grp_o.pads   = 2'd2;
        grp_o.last   = 1'b1;
      end
    endcase
    if (accept_i) begin
      if (in_item_i.final_byte || phase == b64enc_pkg::PhaseTwo) begin
        grp_push_o = 1'b1;
        phase_d    = b64enc_pkg::PhaseStart;
        held_d     = '0;
      end else if (phase == b64enc_pkg::PhaseOne) begin
        phase_d = b64enc_pkg::PhaseTwo;
        held_d  = {held_q[15:8], b};
      end else begin
        phase_d = b64enc_pkg::PhaseOne;
        held_d  = {b, 8'h00};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64enc_pkg::PhaseStart;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

### rtl/b64enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short queue of group descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module b64enc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64enc_pkg::grp_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output b64enc_pkg::grp_t  data_o
);

  b64enc_pkg::grp_t mem_q [b64enc_pkg::QDepth];
  logic [b64enc_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [b64enc_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == b64enc_pkg::QCntW'(b64enc_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == b64enc_pkg::QPtrW'(b64enc_pkg::QDepth - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == b64enc_pkg::QPtrW'(b64enc_pkg::QDepth - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/b64enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Holds one group and hands out its four characters, one per beat.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              grp_valid_i,
  input  b64enc_pkg::grp_t  grp_i,
  output logic              grp_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output b64enc_pkg::out_t  out_item_o
);

  b64enc_pkg::grp_t grp_q, grp_d;
  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  logic       done, load;
  logic [5:0] sextet;
  logic       is_pad;

  assign done      = busy_q && pop_i && (cnt_q == b64enc_pkg::CharLast);
  assign load      = grp_valid_i && (!busy_q || done);
  assign grp_pop_o = load;
  assign empty_o   = !busy_q;

  always_comb begin
    unique case (cnt_q)
      2'd0:    sextet = grp_q.triple[23:18];
      2'd1:    sextet = grp_q.triple[17:12];
      2'd2:    sextet = grp_q.triple[11:6];
      default: sextet = grp_q.triple[5:0];
    endcase
    is_pad = ({1'b0, cnt_q} >= (3'd4 - {1'b0, grp_q.pads}));
    out_item_o.out_char  = is_pad ? b64enc_pkg::PadChar :
                           b64enc_pkg::sextet_to_char(sextet);
    out_item_o.last_char = grp_q.last && (cnt_q == b64enc_pkg::CharLast);
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    grp_d  = grp_q;
    if (busy_q && pop_i) begin
      if (cnt_q == b64enc_pkg::CharLast) begin
        busy_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      grp_d  = grp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTH
  a_idle_count_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 2'd0)
    else $error("Character counter not at zero while idle.");

  a_last_on_fourth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_item_o.last_char) |-> cnt_q == b64enc_pkg::CharLast)
    else $error("Last mark on a character other than the fourth.");

  a_count_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pop_i && cnt_q != b64enc_pkg::CharLast) |=>
      (busy_q && cnt_q == $past(cnt_q) + 2'd1))
    else $error("Character counter did not advance on a beat.");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop_i) |=> (busy_q && $stable(cnt_q) && $stable(out_item_o)))
    else $error("Waiting character changed while stalled.");

  a_pad_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == b64enc_pkg::CharLast && grp_q.pads != 2'd0) |->
      out_item_o.out_char == b64enc_pkg::PadChar)
    else $error("Padded group without a pad as its fourth character.");
`endif

endmodule

### rtl/base64_stream_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder core
// Byte-in, character-out base64 encoder with the standard alphabet and
// '=' padding.
// ----------------------------------------------------------------------------
// One byte is taken per beat and one character is delivered per beat. The
// front end accepts a byte every cycle while full is low; a completed or
// final group enters a two-entry group queue, and the back end hands out its
// four characters one per beat. The one-character output port therefore sets
// the throughput: three input bytes give four characters. The last character
// of a message carries last_char. full is high while the group queue is full.
module base64_stream_encoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  b64enc_pkg::in_t   in_item_i,
  output logic              empty,
  input  logic              pop,
  output b64enc_pkg::out_t  out_item_o
);

  logic             accept;
  logic             grp_push;
  b64enc_pkg::grp_t grp_in;
  logic             q_valid;
  logic             q_pop;
  b64enc_pkg::grp_t q_data;

  assign accept = push && !full;

  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .grp_push_o (grp_push),
    .grp_o      (grp_in)
  );

  b64enc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (q_valid),
    .grp_i       (q_data),
    .grp_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

### sim/b64_char_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 character checker
// Watches the byte and character channels of the stream encoder. It predicts
// the characters each accepted byte produces and compares every popped
// character with the oldest prediction.
// ----------------------------------------------------------------------------
module b64_char_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  b64enc_pkg::in_t  in_item_i,
  input  logic             empty_i,
  input  logic             pop_i,
  input  b64enc_pkg::out_t out_item_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [1:0]       group_phase;
  logic [15:0]      held_bytes;
  b64enc_pkg::out_t expected_chars [$];
  int               mismatches;
  int               chars_checked;

  initial begin
    mismatches    = 0;
    chars_checked = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [7:0] alphabet_char(input logic [5:0] sextet);
    return Alphabet[8*(63 - int'(sextet)) +: 8];
  endfunction

  task automatic encode_beat(input b64enc_pkg::in_t beat);
    logic [23:0]      group_bits;
    int               pads;
    logic             emit;
    b64enc_pkg::out_t ch;
    emit       = 1'b1;
    pads       = 0;
    group_bits = '0;
    case (group_phase)
      b64enc_pkg::PhaseOne: begin
        if (!beat.final_byte) begin
          held_bytes[7:0] = beat.data_byte;
          group_phase     = b64enc_pkg::PhaseTwo;
          emit            = 1'b0;
        end else begin
          group_bits = {held_bytes[15:8], beat.data_byte, 8'h00};
          pads       = 1;
        end
      end
      b64enc_pkg::PhaseTwo: begin
        group_bits = {held_bytes, beat.data_byte};
      end
      default: begin
        if (!beat.final_byte) begin
          held_bytes  = {beat.data_byte, 8'h00};
          group_phase = b64enc_pkg::PhaseOne;
          emit        = 1'b0;
        end else begin
          group_bits = {beat.data_byte, 16'h0000};
          pads       = 2;
        end
      end
    endcase
    if (emit) begin
      for (int k = 0; k < 4; k++) begin
        if (k >= 4 - pads) begin
          ch.out_char = b64enc_pkg::PadChar;
        end else begin
          ch.out_char = alphabet_char(group_bits[6*(3 - k) +: 6]);
        end
        ch.last_char = beat.final_byte && (k == int'(b64enc_pkg::CharLast));
        expected_chars.push_back(ch);
      end
      group_phase = b64enc_pkg::PhaseStart;
      held_bytes  = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    b64enc_pkg::out_t want;
    if (!rst_ni) begin
      group_phase = b64enc_pkg::PhaseStart;
      held_bytes  = '0;
      expected_chars.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last %b",
                                    out_item_i.out_char, out_item_i.last_char));
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_item_i.out_char !== want.out_char) begin
            report_mismatch($sformatf("character %0d: got 0x%02h, expected 0x%02h",
                                      chars_checked, out_item_i.out_char,
                                      want.out_char));
          end
          if (out_item_i.last_char !== want.last_char) begin
            report_mismatch($sformatf("character %0d: last flag %b, expected %b",
                                      chars_checked, out_item_i.last_char,
                                      want.last_char));
          end
        end
      end
      if (push_i && !full_i) begin
        encode_beat(in_item_i);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_chars.size();
    checked_o    <= chars_checked;
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Sends directed and random messages in bursts against a stalling receiver
// and takes the verdict from the character checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RandomBytes = 200;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;
  localparam int NumDirected = 21;

  // Bytes with their end-of-message flag: short messages covering every
  // padding case, all-zero and all-one bytes, and the '+' and '/' characters.
  localparam logic [8:0] DirectedBeats [NumDirected] = '{
    {8'h00, 1'b1},
    {8'hFF, 1'b1},
    {8'hFF, 1'b0}, {8'hFF, 1'b1},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
    {8'hFB, 1'b0}, {8'hEF, 1'b0}, {8'hBE, 1'b1},
    {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
    {8'h4D, 1'b0}, {8'h61, 1'b0}, {8'h6E, 1'b0},
    {8'h80, 1'b0}, {8'h01, 1'b0}, {8'h7F, 1'b1}
  };

  typedef enum int {NoStalls, ShortStalls, LongStalls} stall_mode_e;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             push    = 1'b0;
  logic             pop     = 1'b0;
  b64enc_pkg::in_t  in_item = '0;
  logic             full;
  logic             empty;
  b64enc_pkg::out_t out_item;

  int    fail_count;
  int    pending;
  int    chars_checked;
  int    cycles        = 0;
  int    bytes_sent    = 0;
  int    messages_sent = 0;
  int    burst_left    = 0;

  base64_stream_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  b64_char_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (chars_checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.",
               cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver switches between free running, short stalls and long stalls.
  always @(posedge clk_i) begin
    stall_mode_e stall_mode;
    int          mode_left;
    int          stall_left;
    if (!rst_ni) begin
      stall_mode = NoStalls;
      mode_left  = 0;
      stall_left = 0;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (stall_mode == ShortStalls && $urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 2);
        pop <= 1'b0;
      end else if (stall_mode == LongStalls && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(3, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic is_last);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 8);
    end
    push    <= 1'b1;
    in_item <= '{data_byte: data, final_byte: is_last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
    if (is_last) messages_sent++;
  endtask

  // The checker's outstanding count is registered, so the task waits for the
  // next clock edge before it is trusted.
  task automatic wait_for_drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int msg_len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_byte(DirectedBeats[i][8:1], DirectedBeats[i][0]);
    end
    wait_for_drain();

    while (bytes_sent < NumDirected + RandomBytes) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                            : $urandom_range(1, 9);
      for (int i = 0; i < msg_len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
      end
      if ($urandom_range(0, 7) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Encoded %0d messages of %0d bytes in total, %0d of them directed.",
             messages_sent, bytes_sent, NumDirected);
    $display("Compared %0d characters; %0d mismatches, %0d characters missing.",
             chars_checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
